// File: sv/conveyor_color_sort_control_defines.svh
// Assertion macros used by the checker file of the color sort controller.
`ifndef CONVEYOR_COLOR_SORT_CONTROL_DEFINES_SVH
`define CONVEYOR_COLOR_SORT_CONTROL_DEFINES_SVH

// Overlapping implication, sampled on clk, disabled while rst_n is low.
`define CCS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define CCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ccs_pkg.sv
// Shared types and constants of the conveyor color sort controller.
package ccs_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes, byte address is 4 * index.
  localparam logic [2:0] REG_ALLIANCE = 3'd0;
  localparam logic [2:0] REG_MATCH    = 3'd1;
  localparam logic [2:0] REG_PRESENCE = 3'd2;
  localparam logic [2:0] REG_ARRIVE   = 3'd3;
  localparam logic [2:0] REG_DEPART   = 3'd4;
  localparam logic [2:0] REG_TIMEOUT  = 3'd5;
  localparam logic [2:0] REG_EJECT    = 3'd6;

  // Color codes.
  localparam logic [1:0] COLOR_RED     = 2'd0;
  localparam logic [1:0] COLOR_BLUE    = 2'd1;
  localparam logic [1:0] COLOR_NEUTRAL = 2'd2;

  // Hue window bounds in tenths of a degree (exclusive).
  localparam logic [11:0] HUE_RED_HI_LO = 12'd3400;
  localparam logic [11:0] HUE_RED_HI_HI = 12'd3600;
  localparam logic [11:0] HUE_RED_LO_LO = 12'd0;
  localparam logic [11:0] HUE_RED_LO_HI = 12'd200;
  localparam logic [11:0] HUE_BLUE_LO   = 12'd2100;
  localparam logic [11:0] HUE_BLUE_HI   = 12'd2400;

  // Register reset values.
  localparam logic [1:0] RST_ALLIANCE = COLOR_NEUTRAL;
  localparam logic [1:0] RST_MATCH    = COLOR_NEUTRAL;
  localparam logic [7:0] RST_PRESENCE = 8'd100;
  localparam logic [7:0] RST_ARRIVE   = 8'd220;
  localparam logic [7:0] RST_DEPART   = 8'd130;
  localparam logic [7:0] RST_TIMEOUT  = 8'd50;
  localparam logic [7:0] RST_EJECT    = 8'd7;

  typedef struct packed {
    logic [1:0] alliance_color;
    logic [1:0] match_color;
    logic [7:0] presence_level;
    logic [7:0] arrive_level;
    logic [7:0] depart_level;
    logic [7:0] sort_timeout;
    logic [7:0] eject_ticks;
  } cfg_t;

  typedef struct packed {
    logic [11:0] hue_tenths;
    logic [7:0]  proximity;
    logic        intake_forward;
    logic        jammed;
    logic        match_disabled;
    logic        index_arm;
    logic        index_cancel;
  } item_t;

  typedef struct packed {
    logic [1:0] detected_color;
    logic       eject_active;
    logic       index_stop;
    logic       sorting_active;
  } res_t;

endpackage

// File: sv/ccs_regs.sv
// Configuration register file with APB-style access.
module ccs_regs import ccs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alliance_color <= RST_ALLIANCE;
      cfg_r.match_color    <= RST_MATCH;
      cfg_r.presence_level <= RST_PRESENCE;
      cfg_r.arrive_level   <= RST_ARRIVE;
      cfg_r.depart_level   <= RST_DEPART;
      cfg_r.sort_timeout   <= RST_TIMEOUT;
      cfg_r.eject_ticks    <= RST_EJECT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ALLIANCE: cfg_r.alliance_color <= pwdata[1:0];
        REG_MATCH:    cfg_r.match_color    <= pwdata[1:0];
        REG_PRESENCE: cfg_r.presence_level <= pwdata[7:0];
        REG_ARRIVE:   cfg_r.arrive_level   <= pwdata[7:0];
        REG_DEPART:   cfg_r.depart_level   <= pwdata[7:0];
        REG_TIMEOUT:  cfg_r.sort_timeout   <= pwdata[7:0];
        REG_EJECT:    cfg_r.eject_ticks    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ALLIANCE: prdata = {30'd0, cfg_r.alliance_color};
      REG_MATCH:    prdata = {30'd0, cfg_r.match_color};
      REG_PRESENCE: prdata = {24'd0, cfg_r.presence_level};
      REG_ARRIVE:   prdata = {24'd0, cfg_r.arrive_level};
      REG_DEPART:   prdata = {24'd0, cfg_r.depart_level};
      REG_TIMEOUT:  prdata = {24'd0, cfg_r.sort_timeout};
      REG_EJECT:    prdata = {24'd0, cfg_r.eject_ticks};
      default:      prdata = '0;
    endcase
  end

endmodule

// File: sv/ccs_core.sv
// Hue classifier and sort/index state, updated once per processed tick.
module ccs_core import ccs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic       sort_pending_r, sort_pending_nxt;
  logic       item_arrived_r, item_arrived_nxt;
  logic [7:0] sort_count_r, sort_count_nxt;
  logic [7:0] eject_count_r, eject_count_nxt;
  logic       index_mode_r, index_mode_nxt;

  logic [1:0] color;
  logic       is_red, is_blue, present;
  logic       off_color;
  logic       arrived_now;
  logic [8:0] count_inc;
  logic       eject, stop;

  always_comb begin
    present = item.proximity > cfg.presence_level;
    is_red  = (item.hue_tenths > HUE_RED_HI_LO && item.hue_tenths < HUE_RED_HI_HI) ||
              (item.hue_tenths > HUE_RED_LO_LO && item.hue_tenths < HUE_RED_LO_HI);
    is_blue = item.hue_tenths > HUE_BLUE_LO && item.hue_tenths < HUE_BLUE_HI;
    if (present && is_red) begin
      color = COLOR_RED;
    end else if (present && is_blue) begin
      color = COLOR_BLUE;
    end else begin
      color = COLOR_NEUTRAL;
    end
  end

  assign off_color = (cfg.alliance_color < COLOR_NEUTRAL) && (color < COLOR_NEUTRAL) &&
                     (cfg.alliance_color != color);
  assign count_inc   = {1'b0, sort_count_r} + 9'd1;
  assign arrived_now = item_arrived_r ||
                       (item.proximity > cfg.arrive_level && item.intake_forward);

  always_comb begin
    sort_pending_nxt = sort_pending_r;
    item_arrived_nxt = item_arrived_r;
    sort_count_nxt   = sort_count_r;
    eject_count_nxt  = eject_count_r;
    eject            = 1'b0;
    stop             = 1'b0;
    // Cancel wins over arm.
    index_mode_nxt   = (index_mode_r || item.index_arm) && !item.index_cancel;

    if (eject_count_r != 8'd0) begin
      eject_count_nxt = eject_count_r - 8'd1;
      eject           = 1'b1;
    end else if (!item.jammed && !item.match_disabled) begin
      if (off_color && !sort_pending_r) begin
        sort_pending_nxt = 1'b1;
      end else if (sort_pending_r) begin
        if (arrived_now && item.proximity < cfg.depart_level) begin
          // This tick is the first eject tick.
          eject            = 1'b1;
          eject_count_nxt  = (cfg.eject_ticks != 8'd0) ? cfg.eject_ticks - 8'd1 : 8'd0;
          sort_pending_nxt = 1'b0;
          item_arrived_nxt = 1'b0;
          sort_count_nxt   = 8'd0;
        end else if (count_inc > {1'b0, cfg.sort_timeout}) begin
          // Give up but keep the arrival mark.
          sort_pending_nxt = 1'b0;
          item_arrived_nxt = arrived_now;
          sort_count_nxt   = 8'd0;
        end else begin
          item_arrived_nxt = arrived_now;
          sort_count_nxt   = count_inc[7:0];
        end
      end else if (index_mode_nxt) begin
        if (cfg.match_color == color && cfg.match_color != COLOR_NEUTRAL) begin
          stop           = 1'b1;
          index_mode_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_pending_r <= 1'b0;
      item_arrived_r <= 1'b0;
      sort_count_r   <= 8'd0;
      eject_count_r  <= 8'd0;
      index_mode_r   <= 1'b0;
    end else if (step) begin
      sort_pending_r <= sort_pending_nxt;
      item_arrived_r <= item_arrived_nxt;
      sort_count_r   <= sort_count_nxt;
      eject_count_r  <= eject_count_nxt;
      index_mode_r   <= index_mode_nxt;
    end
  end

  assign res.detected_color = color;
  assign res.eject_active   = eject;
  assign res.index_stop     = stop;
  assign res.sorting_active = sort_pending_nxt || eject;

endmodule

// File: sv/conveyor_color_sort_control.sv
// Conveyor color sort controller: top level with input and result registers.
// One request is one control tick. A tick is taken into the input register, decided by the
// classifier and sort state logic while it is held there, and its result is registered in
// the result register as the tick leaves the input register. One request is taken every
// cycle while the result side keeps up. in_stall rises only when both the input and result
// registers are full and out_stall is high. Configuration registers sit at byte addresses
// 0x00 to 0x18, one per word; write them only while the block is idle.
module conveyor_color_sort_control import ccs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [11:0]       in_hue_tenths,
  input  logic [7:0]        in_proximity,
  input  logic              in_intake_forward,
  input  logic              in_jammed,
  input  logic              in_match_disabled,
  input  logic              in_index_arm,
  input  logic              in_index_cancel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_detected_color,
  output logic              out_eject_active,
  output logic              out_index_stop,
  output logic              out_sorting_active,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  item_t s1_item_r;
  logic  s1_valid_r;
  res_t  res;
  res_t  out_res_r;
  logic  out_valid_r;
  logic  advance;
  logic  in_take;

  ccs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Move the held request into the result register when that slot is free or draining.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.hue_tenths     <= in_hue_tenths;
      s1_item_r.proximity      <= in_proximity;
      s1_item_r.intake_forward <= in_intake_forward;
      s1_item_r.jammed         <= in_jammed;
      s1_item_r.match_disabled <= in_match_disabled;
      s1_item_r.index_arm      <= in_index_arm;
      s1_item_r.index_cancel   <= in_index_cancel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_detected_color = out_res_r.detected_color;
  assign out_eject_active   = out_res_r.eject_active;
  assign out_index_stop     = out_res_r.index_stop;
  assign out_sorting_active = out_res_r.sorting_active;

endmodule

// File: sv/ccs_checker.sv
// Port-level checker for the color sort controller and its bind.
`include "conveyor_color_sort_control_defines.svh"

module ccs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_detected_color,
  input logic       out_eject_active,
  input logic       out_index_stop,
  input logic       out_sorting_active
);

  `CCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_detected_color) && $stable(out_eject_active) && $stable(out_index_stop) && $stable(out_sorting_active), "stalled result changed")
  `CCS_ASSERT_IMPL(a_eject_sorting, out_valid && out_eject_active, out_sorting_active, "eject without sorting_active")
  `CCS_ASSERT_IMPL(a_stop_no_eject, out_valid && out_index_stop, !out_eject_active && !out_sorting_active, "index stop during a sort")
  `CCS_ASSERT_IMPL(a_color_code, out_valid, out_detected_color != 2'd3, "illegal color code")
  `CCS_ASSERT_NEXT(a_accept_flows, in_valid && !in_stall && !out_stall, out_valid || !in_stall, "accepted request lost")

endmodule

bind conveyor_color_sort_control ccs_checker u_ccs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_detected_color (out_detected_color),
  .out_eject_active   (out_eject_active),
  .out_index_stop     (out_index_stop),
  .out_sorting_active (out_sorting_active)
);
